// ===== src/sdrm_pkg.sv =====
// Shared constants, codes and types for the smoothed deadband range mapper.
// Used by the channel interfaces, the divider, controller, datapath and top level.
package sdrm_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int FRAC_BITS     = 16;
  localparam int WEIGHT_FRAC   = 16;
  localparam int WEIGHT_BITS   = WEIGHT_FRAC + 1;
  localparam int DATA_BITS     = 32;
  localparam int INDEX_BITS    = 3;
  localparam int DIFF_BITS     = SAMPLE_BITS + 1;
  localparam int PROD_BITS     = DATA_BITS + DIFF_BITS;
  localparam int SUM_BITS      = PROD_BITS + 2;
  localparam int NUM_BITS      = DATA_BITS + 1;
  localparam int DIVIDEND_BITS = NUM_BITS + 1;
  localparam int DIV_STEPS     = DIVIDEND_BITS;
  localparam int STEP_BITS     = $clog2(DIV_STEPS + 1);

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC;
  localparam logic [PROD_BITS-1:0]   ROUND_HALF = PROD_BITS'(1) << (WEIGHT_FRAC - 1);

  localparam logic signed [DATA_BITS-1:0] I32_MAX_V = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam logic signed [DATA_BITS-1:0] I32_MIN_V = {1'b1, {(DATA_BITS-1){1'b0}}};

  // Reset values of the high ends and the slope that the divider would give for them.
  localparam longint I32_MAX_L    = 64'sd2147483647;
  localparam longint SAMPLE_MAX_L = (longint'(1) << SAMPLE_BITS) - 1;
  localparam longint TOP_L        = SAMPLE_MAX_L << FRAC_BITS;
  localparam longint OUT_HIGH_L   = (TOP_L > I32_MAX_L) ? I32_MAX_L : TOP_L;
  localparam longint SLOPE_Q_L    = (2 * OUT_HIGH_L + SAMPLE_MAX_L) / (2 * SAMPLE_MAX_L);
  localparam longint SLOPE_L      = (SLOPE_Q_L > I32_MAX_L) ? I32_MAX_L : SLOPE_Q_L;

  localparam logic [SAMPLE_BITS-1:0]      IN_HIGH_RST  = {SAMPLE_BITS{1'b1}};
  localparam logic signed [DATA_BITS-1:0] OUT_HIGH_RST = DATA_BITS'(OUT_HIGH_L);
  localparam logic signed [DATA_BITS-1:0] SLOPE_RST    = DATA_BITS'(SLOPE_L);

  typedef enum logic [INDEX_BITS-1:0] {
    IDX_INPUT_LOW        = 3'd0,
    IDX_INPUT_HIGH       = 3'd1,
    IDX_OUTPUT_LOW       = 3'd2,
    IDX_OUTPUT_HIGH      = 3'd3,
    IDX_CHANGE_THRESHOLD = 3'd4,
    IDX_OUTPUT_OFFSET    = 3'd5,
    IDX_SMOOTHING_WEIGHT = 3'd6,
    IDX_SMOOTHING_ON     = 3'd7
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_B,
    S_DECIDE,
    S_MAP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_b;
    logic decide;
    logic map;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic outside;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/sdrm_ifs.sv =====
// Valid/ready channel interfaces for sample words and result words.
// Depends on sdrm_pkg for the field widths.
interface sdrm_sample_if;
  logic                              valid;
  logic                              ready;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sdrm_result_if;
  logic                                    valid;
  logic                                    ready;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]        accepted_value;
  logic signed [sdrm_pkg::DATA_BITS-1:0]   mapped_value;

  modport source (output valid, output accepted_value, output mapped_value, input ready);
  modport sink   (input valid, input accepted_value, input mapped_value, output ready);
endinterface

// ===== src/sdrm_div.sv =====
// Bit-serial slope divider: round((out_high - out_low) / (in_high - in_low)).
// Depends on sdrm_pkg; instantiated by sdrm_dp.
module sdrm_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [sdrm_pkg::NUM_BITS-1:0]  num,
  input  logic signed [sdrm_pkg::DIFF_BITS-1:0] den,
  output logic                                  busy,
  output logic signed [sdrm_pkg::DATA_BITS-1:0] slope
);

  logic [sdrm_pkg::NUM_BITS-1:0]      abs_num;
  logic [sdrm_pkg::DIFF_BITS-1:0]     abs_den_w;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]   abs_den;
  logic [sdrm_pkg::DIVIDEND_BITS-1:0] quo;
  logic [sdrm_pkg::DIFF_BITS-1:0]     d2;
  logic [sdrm_pkg::DIFF_BITS-1:0]     rem;
  logic [sdrm_pkg::DIFF_BITS:0]       shifted;
  logic [sdrm_pkg::DIFF_BITS:0]       diff;
  logic                               fits;
  logic                               neg;
  logic                               running;
  logic [sdrm_pkg::STEP_BITS-1:0]     count;
  logic                               big;
  logic signed [sdrm_pkg::DATA_BITS-1:0] slope_next;

  always_comb begin
    abs_num   = num[sdrm_pkg::NUM_BITS-1] ? sdrm_pkg::NUM_BITS'(-num) : num;
    abs_den_w = den[sdrm_pkg::DIFF_BITS-1] ? sdrm_pkg::DIFF_BITS'(-den) : den;
    abs_den   = abs_den_w[sdrm_pkg::SAMPLE_BITS-1:0];
    shifted   = {rem, quo[sdrm_pkg::DIVIDEND_BITS-1]};
    diff      = shifted - {1'b0, d2};
    fits      = shifted >= {1'b0, d2};
    // Quotient is clamped to 2^31 before the sign is applied, then saturated.
    big       = |quo[sdrm_pkg::DIVIDEND_BITS-1:sdrm_pkg::DATA_BITS-1];
    if (neg) begin
      slope_next = big ? sdrm_pkg::I32_MIN_V : -$signed(quo[sdrm_pkg::DATA_BITS-1:0]);
    end else begin
      slope_next = big ? sdrm_pkg::I32_MAX_V : $signed(quo[sdrm_pkg::DATA_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
      slope   <= sdrm_pkg::SLOPE_RST;
    end else if (start) begin
      neg <= num[sdrm_pkg::NUM_BITS-1] ^ den[sdrm_pkg::DIFF_BITS-1];
      rem <= '0;
      quo <= {abs_num, 1'b0} + sdrm_pkg::DIVIDEND_BITS'(abs_den);
      d2  <= {abs_den, 1'b0};
      if (den == '0) begin
        slope   <= '0;
        running <= 1'b0;
      end else begin
        running <= 1'b1;
        count   <= sdrm_pkg::STEP_BITS'(sdrm_pkg::DIV_STEPS);
      end
    end else if (running) begin
      if (count != '0) begin
        rem   <= fits ? diff[sdrm_pkg::DIFF_BITS-1:0] : shifted[sdrm_pkg::DIFF_BITS-1:0];
        quo   <= {quo[sdrm_pkg::DIVIDEND_BITS-2:0], fits};
        count <= count - 1'b1;
      end else begin
        slope   <= slope_next;
        running <= 1'b0;
      end
    end
  end

  assign busy = running;

endmodule

// ===== src/sdrm_ctrl.sv =====
// Sequencing state machine: steps each sample word through the shared multiplier.
// Depends on sdrm_pkg for the state, command and status types.
module sdrm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sdrm_pkg::dp_status_t  status,
  output sdrm_pkg::dp_cmd_t     cmd
);

  sdrm_pkg::state_t state;
  sdrm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdrm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    unique case (state)
      sdrm_pkg::S_IDLE: begin
        sample_ready = !status.div_busy;
        if (sample_valid && !status.div_busy) begin
          cmd.load   = 1'b1;
          state_next = sdrm_pkg::S_MUL_B;
        end
      end
      sdrm_pkg::S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = sdrm_pkg::S_DECIDE;
      end
      sdrm_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.outside ? sdrm_pkg::S_MAP : sdrm_pkg::S_IDLE;
      end
      sdrm_pkg::S_MAP: begin
        cmd.map    = 1'b1;
        state_next = sdrm_pkg::S_EMIT;
      end
      sdrm_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sdrm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sdrm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sdrm_dp.sv =====
// Datapath: configuration registers, shared multiplier, deadband test, output register.
// Depends on sdrm_pkg and instantiates the slope divider sdrm_div.
module sdrm_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [sdrm_pkg::INDEX_BITS-1:0]        wr_index,
  input  logic [sdrm_pkg::DATA_BITS-1:0]         wr_data,
  input  logic [sdrm_pkg::SAMPLE_BITS-1:0]       sample,
  input  sdrm_pkg::dp_cmd_t                      cmd,
  output sdrm_pkg::dp_status_t                   status,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [sdrm_pkg::SAMPLE_BITS-1:0]       accepted_value,
  output logic signed [sdrm_pkg::DATA_BITS-1:0]  mapped_value
);

  logic [sdrm_pkg::SAMPLE_BITS-1:0]      in_low;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]      in_high;
  logic signed [sdrm_pkg::DATA_BITS-1:0] out_low;
  logic signed [sdrm_pkg::DATA_BITS-1:0] out_high;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]      threshold;
  logic signed [sdrm_pkg::DATA_BITS-1:0] offset;
  logic [sdrm_pkg::WEIGHT_BITS-1:0]      weight;
  logic                                  smooth_on;
  logic                                  div_start;

  logic [sdrm_pkg::SAMPLE_BITS-1:0]      x;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]      held;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]      avg_a;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]      v;
  logic signed [sdrm_pkg::PROD_BITS-1:0] prod;

  logic signed [sdrm_pkg::NUM_BITS-1:0]  num;
  logic signed [sdrm_pkg::DIFF_BITS-1:0] den;
  logic                                  div_busy;
  logic signed [sdrm_pkg::DATA_BITS-1:0] slope;

  logic [sdrm_pkg::WEIGHT_BITS-1:0]      w;
  logic [sdrm_pkg::WEIGHT_BITS-1:0]      w_inv;
  logic signed [sdrm_pkg::DATA_BITS-1:0] ma;
  logic signed [sdrm_pkg::DIFF_BITS-1:0] mb;
  logic signed [sdrm_pkg::PROD_BITS-1:0] prod_next;
  logic [sdrm_pkg::PROD_BITS-1:0]        rounded;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]      smoothed;
  logic [sdrm_pkg::SAMPLE_BITS-1:0]      v_cand;
  logic [sdrm_pkg::DIFF_BITS-1:0]        upper;
  logic [sdrm_pkg::DIFF_BITS-1:0]        cand_up;
  logic signed [sdrm_pkg::SUM_BITS-1:0]  sum;
  logic [sdrm_pkg::SUM_BITS-sdrm_pkg::DATA_BITS:0] sum_top;
  logic signed [sdrm_pkg::DATA_BITS-1:0] mapped_next;

  // Configuration registers; a write to a range register restarts the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_low    <= '0;
      in_high   <= sdrm_pkg::IN_HIGH_RST;
      out_low   <= '0;
      out_high  <= sdrm_pkg::OUT_HIGH_RST;
      threshold <= '0;
      offset    <= '0;
      weight    <= sdrm_pkg::WEIGHT_ONE;
      smooth_on <= 1'b1;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (wr_en) begin
        unique case (sdrm_pkg::cfg_index_t'(wr_index))
          sdrm_pkg::IDX_INPUT_LOW: begin
            in_low    <= wr_data[sdrm_pkg::SAMPLE_BITS-1:0];
            div_start <= 1'b1;
          end
          sdrm_pkg::IDX_INPUT_HIGH: begin
            in_high   <= wr_data[sdrm_pkg::SAMPLE_BITS-1:0];
            div_start <= 1'b1;
          end
          sdrm_pkg::IDX_OUTPUT_LOW: begin
            out_low   <= $signed(wr_data);
            div_start <= 1'b1;
          end
          sdrm_pkg::IDX_OUTPUT_HIGH: begin
            out_high  <= $signed(wr_data);
            div_start <= 1'b1;
          end
          sdrm_pkg::IDX_CHANGE_THRESHOLD: threshold <= wr_data[sdrm_pkg::SAMPLE_BITS-1:0];
          sdrm_pkg::IDX_OUTPUT_OFFSET:    offset    <= $signed(wr_data);
          sdrm_pkg::IDX_SMOOTHING_WEIGHT: weight    <= wr_data[sdrm_pkg::WEIGHT_BITS-1:0];
          sdrm_pkg::IDX_SMOOTHING_ON:     smooth_on <= wr_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    num = {out_high[sdrm_pkg::DATA_BITS-1], out_high} - {out_low[sdrm_pkg::DATA_BITS-1], out_low};
    den = {1'b0, in_high} - {1'b0, in_low};
  end

  sdrm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .slope (slope)
  );

  // One multiplier serves the two averaging products and the map product.
  always_comb begin
    w     = (weight > sdrm_pkg::WEIGHT_ONE) ? sdrm_pkg::WEIGHT_ONE : weight;
    w_inv = sdrm_pkg::WEIGHT_ONE - w;
    ma    = '0;
    mb    = '0;
    if (cmd.load) begin
      ma = $signed({{(sdrm_pkg::DATA_BITS-sdrm_pkg::WEIGHT_BITS){1'b0}}, w});
      mb = $signed({1'b0, sample});
    end else if (cmd.mul_b) begin
      ma = $signed({{(sdrm_pkg::DATA_BITS-sdrm_pkg::WEIGHT_BITS){1'b0}}, w_inv});
      mb = $signed({1'b0, held});
    end else if (cmd.map) begin
      ma = slope;
      mb = $signed({1'b0, v} - {1'b0, in_low});
    end
    prod_next = ma * mb;
  end

  // Averaging and deadband test on the products held in prod and avg_a.
  always_comb begin
    rounded  = prod + sdrm_pkg::ROUND_HALF;
    smoothed = avg_a + prod[sdrm_pkg::WEIGHT_FRAC +: sdrm_pkg::SAMPLE_BITS];
    v_cand   = smooth_on ? smoothed : x;
    upper    = {1'b0, held} + {1'b0, threshold};
    cand_up  = {1'b0, v_cand} + {1'b0, threshold};
    status.outside  = ({1'b0, v_cand} > upper) || (cand_up < {1'b0, held});
    status.div_busy = div_start || div_busy;
    status.out_free = !out_valid || out_ready;
  end

  // Exact sum of the three terms, saturated to the signed output width.
  always_comb begin
    sum = $signed({{(sdrm_pkg::SUM_BITS-sdrm_pkg::DATA_BITS){out_low[sdrm_pkg::DATA_BITS-1]}},
                   out_low})
        + $signed({{(sdrm_pkg::SUM_BITS-sdrm_pkg::PROD_BITS){prod[sdrm_pkg::PROD_BITS-1]}}, prod})
        + $signed({{(sdrm_pkg::SUM_BITS-sdrm_pkg::DATA_BITS){offset[sdrm_pkg::DATA_BITS-1]}},
                   offset});
    sum_top = sum[sdrm_pkg::SUM_BITS-1:sdrm_pkg::DATA_BITS-1];
    if ((&sum_top) || !(|sum_top)) begin
      mapped_next = sum[sdrm_pkg::DATA_BITS-1:0];
    end else if (sum[sdrm_pkg::SUM_BITS-1]) begin
      mapped_next = sdrm_pkg::I32_MIN_V;
    end else begin
      mapped_next = sdrm_pkg::I32_MAX_V;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= sample;
    end
    if (cmd.load || cmd.mul_b || cmd.map) begin
      prod <= prod_next;
    end
    if (cmd.mul_b) begin
      avg_a <= rounded[sdrm_pkg::WEIGHT_FRAC +: sdrm_pkg::SAMPLE_BITS];
    end
    if (cmd.decide && status.outside) begin
      v <= v_cand;
    end
    if (cmd.emit) begin
      accepted_value <= v;
      mapped_value   <= mapped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decide && status.outside) begin
        held <= v_cand;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/smoothed_deadband_range_mapper_unit.sv =====
// Top level of the smoothed deadband range mapper: controller plus datapath.
// Depends on sdrm_pkg, the channel interfaces in sdrm_ifs, sdrm_ctrl and sdrm_dp.

// Each sample word is optionally smoothed against the held value as
// round(w*x) + trunc((1-w)*held), then compared against the held value with a
// deadband of plus or minus change_threshold. A value outside the band becomes
// the new held value and leaves as a result word together with its Q16.16 map
// output_low + (v - input_low) * slope + output_offset, saturated to 32 bits; a
// value inside the band produces no result word. All products go through one
// shared 32 by 11 bit multiplier, so words are taken one at a time: a word inside
// the deadband passes through S_MUL_B and S_DECIDE before the next word can be
// taken, and a word that produces a result goes on through S_MAP and S_EMIT. The
// result sits in an output register, so a new sample word is accepted while the
// previous result waits on the consumer; only when a second result is ready before
// the first was taken does the block hold. Writing input_low, input_high,
// output_low or output_high restarts a bit-serial slope divider, one quotient bit
// per cycle, and sample words are not accepted until it is done after the last
// such write. Equal input ends give a slope of zero. Configuration must be written
// only while no word is in flight; the block itself does not enforce this.
module smoothed_deadband_range_mapper_unit (
  input  logic                              clk,
  input  logic                              rst,
  sdrm_sample_if.sink                       samples,
  sdrm_result_if.source                     results,
  input  logic                              wr_en,
  input  logic [sdrm_pkg::INDEX_BITS-1:0]   wr_index,
  input  logic [sdrm_pkg::DATA_BITS-1:0]    wr_data
);

  sdrm_pkg::dp_cmd_t    cmd;
  sdrm_pkg::dp_status_t status;

  // The controller only sequences; every data register lives in the datapath.
  sdrm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (samples.valid),
    .sample_ready (samples.ready),
    .status       (status),
    .cmd          (cmd)
  );

  sdrm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .sample         (samples.sample),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (results.ready),
    .out_valid      (results.valid),
    .accepted_value (results.accepted_value),
    .mapped_value   (results.mapped_value)
  );

`ifndef NO_ASSERTIONS
  // An accepted sample word must be followed by the second averaging product.
  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> cmd.mul_b)
    else $error("accepted word did not advance to the second product");

  // A new result must never overwrite one that the consumer has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!results.valid || results.ready))
    else $error("result register overwritten while still pending");

  // A range write restarts the divider, so no sample word may enter next cycle.
  a_range_write_blocks: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (wr_index == sdrm_pkg::IDX_INPUT_LOW || wr_index == sdrm_pkg::IDX_INPUT_HIGH ||
               wr_index == sdrm_pkg::IDX_OUTPUT_LOW || wr_index == sdrm_pkg::IDX_OUTPUT_HIGH))
    |=> !samples.ready)
    else $error("sample accepted while slope was being recomputed");
`endif

endmodule

// ===== test/smoothed_deadband_range_mapper_unit_tb.sv =====
// Self-checking testbench for smoothed_deadband_range_mapper_unit.
// Depends on sdrm_pkg, the channel interfaces in sdrm_ifs and the unit itself.
module smoothed_deadband_range_mapper_unit_tb;
  import sdrm_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 115;
  localparam int QUIET_ITEMS   = 30;
  localparam int NUM_ROWS      = 37;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0]      accepted_value;
    logic signed [DATA_BITS-1:0] mapped_value;
  } mapper_word_t;

  // A row of the directed plan is either a register write or a sample word. For a
  // sample word the expected outcome is either typed in or left to the predictor.
  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_WORD} row_check_t;

  typedef struct packed {
    row_kind_t                   kind;
    cfg_index_t                  idx;
    logic [DATA_BITS-1:0]        data;
    logic [SAMPLE_BITS-1:0]      value;
    row_check_t                  check;
    logic [SAMPLE_BITS-1:0]      acc;
    logic signed [DATA_BITS-1:0] mapped;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_index;
  logic [DATA_BITS-1:0]  wr_data;

  sdrm_sample_if sample_ch ();
  sdrm_result_if result_ch ();

  smoothed_deadband_range_mapper_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_ch),
    .results  (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Shadow copy of the configuration and of the block's state.
  logic [SAMPLE_BITS-1:0]      cfg_in_low;
  logic [SAMPLE_BITS-1:0]      cfg_in_high;
  logic signed [DATA_BITS-1:0] cfg_out_low;
  logic signed [DATA_BITS-1:0] cfg_out_high;
  logic [SAMPLE_BITS-1:0]      cfg_threshold;
  logic signed [DATA_BITS-1:0] cfg_offset;
  logic [WEIGHT_BITS-1:0]      cfg_weight;
  logic                        cfg_smooth;
  logic [SAMPLE_BITS-1:0]      shadow_held;
  longint                      shadow_slope;

  // Result words predicted but not yet seen, oldest first.
  mapper_word_t pending_words[$];
  int           mismatch_count;
  int           cycle_count;

  // Traffic shaping: calm turns off all random idling, hold_req asks the result
  // side for one long hold-off.
  bit calm;
  bit hold_req;

  // Directed plan. It starts from reset values, walks the deadband edges, the
  // weight extremes (half, above one, zero), saturation at both ends, equal and
  // reversed input ends and the largest positive slope.
  plan_row_t directed_plan [NUM_ROWS] = '{
    // Straight after reset: full scale, slope 1.0, no deadband, no smoothing effect.
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd0, EXP_NONE, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd1023, EXP_WORD, 10'd1023, 32'sd67043328},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd512, EXP_WORD, 10'd512, 32'sd33554432},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd512, EXP_NONE, 10'd0, 32'sd0},
    // Deadband of ten counts around 512, then around 523.
    '{ROW_CFG, IDX_CHANGE_THRESHOLD, 32'd10, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd520, EXP_NONE, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd523, EXP_WORD, 10'd523, 32'sd34275328},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd513, EXP_NONE, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd512, EXP_WORD, 10'd512, 32'sd33554432},
    // Half weight averaging.
    '{ROW_CFG, IDX_CHANGE_THRESHOLD, 32'd0, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_SMOOTHING_WEIGHT, 32'd32768, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd1023, EXP_MODEL, 10'd0, 32'sd0},
    // A weight above one acts as one; a weight of zero never moves the value.
    '{ROW_CFG, IDX_SMOOTHING_WEIGHT, 32'h0001_FFFF, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd1, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_SMOOTHING_WEIGHT, 32'd0, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd1023, EXP_MODEL, 10'd0, 32'sd0},
    // Smoothing off, offset at the top: the map saturates high.
    '{ROW_CFG, IDX_SMOOTHING_ON, 32'd0, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_OUTPUT_OFFSET, 32'h7FFF_FFFF, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd1023, EXP_WORD, 10'd1023, I32_MAX_V},
    // Output low and offset both at the bottom: the map saturates low.
    '{ROW_CFG, IDX_OUTPUT_LOW, 32'h8000_0000, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_OUTPUT_OFFSET, 32'h8000_0000, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd0, EXP_WORD, 10'd0, I32_MIN_V},
    // Equal input ends: slope zero, every word maps to output low plus offset.
    '{ROW_CFG, IDX_INPUT_LOW, 32'd300, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_INPUT_HIGH, 32'd300, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_OUTPUT_LOW, 32'd5, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_OUTPUT_OFFSET, 32'd0, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd700, EXP_WORD, 10'd700, 32'sd5},
    // Reversed input range with a large output span.
    '{ROW_CFG, IDX_INPUT_LOW, 32'd1023, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_INPUT_HIGH, 32'd0, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_OUTPUT_HIGH, 32'h7FFF_FFFF, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    // One count of input across the full output span: the slope saturates.
    '{ROW_CFG, IDX_INPUT_LOW, 32'd0, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_INPUT_HIGH, 32'd1, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_CFG, IDX_OUTPUT_LOW, 32'h8000_0000, 10'd0, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd1023, EXP_MODEL, 10'd0, 32'sd0},
    '{ROW_SAMPLE, IDX_INPUT_LOW, 32'd0, 10'd1, EXP_MODEL, 10'd0, 32'sd0}
  };

  function automatic logic signed [DATA_BITS-1:0] saturate32(input longint v);
    if (v > longint'(I32_MAX_V)) return I32_MAX_V;
    if (v < longint'(I32_MIN_V)) return I32_MIN_V;
    return v[DATA_BITS-1:0];
  endfunction

  // Slope of the map: output span over input span, rounded to nearest with ties
  // away from zero, clamped to 32 bits. Equal input ends give zero.
  function automatic longint divide_slope();
    longint          num;
    longint          den;
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    bit              neg;
    num = longint'(cfg_out_high) - longint'(cfg_out_low);
    den = longint'(cfg_in_high) - longint'(cfg_in_low);
    if (den == 0) return 0;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return longint'(saturate32(neg ? -longint'(q) : longint'(q)));
  endfunction

  // Mirror of the register file. Range registers refresh the slope.
  function automatic void apply_write(input cfg_index_t idx, input logic [DATA_BITS-1:0] data);
    case (idx)
      IDX_INPUT_LOW: begin
        cfg_in_low = data[SAMPLE_BITS-1:0];
        shadow_slope = divide_slope();
      end
      IDX_INPUT_HIGH: begin
        cfg_in_high = data[SAMPLE_BITS-1:0];
        shadow_slope = divide_slope();
      end
      IDX_OUTPUT_LOW: begin
        cfg_out_low = data;
        shadow_slope = divide_slope();
      end
      IDX_OUTPUT_HIGH: begin
        cfg_out_high = data;
        shadow_slope = divide_slope();
      end
      IDX_CHANGE_THRESHOLD: cfg_threshold = data[SAMPLE_BITS-1:0];
      IDX_OUTPUT_OFFSET:    cfg_offset = data;
      IDX_SMOOTHING_WEIGHT: cfg_weight = data[WEIGHT_BITS-1:0];
      IDX_SMOOTHING_ON:     cfg_smooth = data[0];
      default: ;
    endcase
  endfunction

  // Smooths one sample, applies the deadband and maps the survivor. Returns 1
  // and fills word when the sample leaves the band, which also moves the held
  // value; returns 0 and leaves the state alone otherwise.
  function automatic bit smooth_and_map(input logic [SAMPLE_BITS-1:0] x,
                                        output mapper_word_t word);
    longint unsigned        w_one;
    longint unsigned        w;
    longint unsigned        a;
    longint unsigned        b;
    logic [SAMPLE_BITS-1:0] v;
    longint                 hv;
    longint                 sv;
    longint                 th;
    longint                 mapped;
    word = '0;
    w_one = longint'(WEIGHT_ONE);
    v = x;
    if (cfg_smooth) begin
      w = (cfg_weight > WEIGHT_ONE) ? w_one : longint'(cfg_weight);
      a = (w * x + (w_one >> 1)) >> WEIGHT_FRAC;
      b = ((w_one - w) * shadow_held) >> WEIGHT_FRAC;
      v = SAMPLE_BITS'(a + b);
    end
    hv = longint'(shadow_held);
    sv = longint'(v);
    th = longint'(cfg_threshold);
    if (!(sv > hv + th || sv < hv - th)) return 0;
    shadow_held = v;
    mapped = longint'(cfg_out_low) + (sv - longint'(cfg_in_low)) * shadow_slope
           + longint'(cfg_offset);
    word.accepted_value = v;
    word.mapped_value = saturate32(mapped);
    return 1;
  endfunction

  // Random upper bits above a narrow register value; the block must ignore them.
  function automatic logic [DATA_BITS-1:0] with_noise_bits(input logic [DATA_BITS-1:0] val,
                                                           input int width);
    return (DATA_BITS'($urandom) << width) | val;
  endfunction

  // A full-range 32 bit value or one in a span small enough not to saturate.
  function automatic logic [DATA_BITS-1:0] pick_q16();
    if ($urandom_range(0, 1) == 1) return $urandom;
    return DATA_BITS'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
  endfunction

  // 45 in 100 samples sit close to the band edges around the held value, 10 are
  // the two rails and the rest uniform noise.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    int t;
    int s;
    r = $urandom_range(0, 99);
    t = int'(cfg_threshold);
    if (r < 45) begin
      s = int'(shadow_held) + int'($urandom_range(0, 2 * t + 4)) - (t + 2);
      if (s < 0) s = 0;
      if (s > 1023) s = 1023;
    end else if (r < 55) begin
      s = ($urandom_range(0, 1) == 1) ? 1023 : 0;
    end else begin
      s = $urandom_range(0, 1023);
    end
    return SAMPLE_BITS'(s);
  endfunction

  // Offers one sample word and returns once it has been taken. Valid stays high
  // afterwards so that back-to-back words need no extra edge.
  task automatic offer_sample(input logic [SAMPLE_BITS-1:0] x);
    if (!calm) begin
      while ($urandom_range(0, 99) < 32) begin
        sample_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= x;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Offers a sample word and records the word it should cause, if any.
  task automatic feed_sample(input logic [SAMPLE_BITS-1:0] x);
    mapper_word_t w;
    offer_sample(x);
    if (smooth_and_map(x, w)) pending_words.push_back(w);
  endtask

  // Stops offering and waits until every expected word has come back, then waits
  // out the settle time so that a sample inside the band has also finished.
  task automatic settle_block();
    sample_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes go back to back; cfg_close drops the enable afterwards.
  task automatic cfg_write(input cfg_index_t idx, input logic [DATA_BITS-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    apply_write(idx, data);
  endtask

  task automatic cfg_close();
    wr_en <= 1'b0;
  endtask

  task automatic note_mismatch(input string why, input mapper_word_t want,
                               input mapper_word_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH %s: expected accepted=%0d mapped=%0d, got accepted=%0d mapped=%0d",
               why, want.accepted_value, want.mapped_value,
               got.accepted_value, got.mapped_value);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side. Ready drops in about a third of the cycles, never while calm,
  // and stays low for one long stretch when the stimulus asks for it, so that
  // the output register fills and the block stops taking sample words.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_ch.ready <= calm || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Every word taken from the result channel is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin : check_words
    mapper_word_t got;
    mapper_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.accepted_value = result_ch.accepted_value;
      got.mapped_value = result_ch.mapped_value;
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = pending_words.pop_front();
        if (got.accepted_value !== want.accepted_value ||
            got.mapped_value !== want.mapped_value)
          note_mismatch("wrong word", want, got);
      end
    end
  end

  // Stimulus: reset, the directed plan, then random phases with a fresh
  // configuration each.
  initial begin
    mapper_word_t           w;
    bit                     hit;
    bit                     last_was_sample;
    int                     items;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] th;
    logic [DATA_BITS-1:0]   ol;
    logic [DATA_BITS-1:0]   oh;
    logic [DATA_BITS-1:0]   off;
    logic [WEIGHT_BITS-1:0] wt;
    logic                   on;

    mismatch_count = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    cfg_in_low = '0;
    cfg_in_high = IN_HIGH_RST;
    cfg_out_low = '0;
    cfg_out_high = OUT_HIGH_RST;
    cfg_threshold = '0;
    cfg_offset = '0;
    cfg_weight = WEIGHT_ONE;
    cfg_smooth = 1'b1;
    shadow_held = '0;
    shadow_slope = divide_slope();

    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.sample <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed plan. Register rows are only reached with the block idle.
    last_was_sample = 1'b1;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        if (last_was_sample) settle_block();
        cfg_write(directed_plan[i].idx, directed_plan[i].data);
        last_was_sample = 1'b0;
      end else begin
        if (!last_was_sample) cfg_close();
        offer_sample(directed_plan[i].value);
        hit = smooth_and_map(directed_plan[i].value, w);
        case (directed_plan[i].check)
          EXP_MODEL: if (hit) pending_words.push_back(w);
          EXP_WORD: begin
            w.accepted_value = directed_plan[i].acc;
            w.mapped_value = directed_plan[i].mapped;
            pending_words.push_back(w);
          end
          default: ;
        endcase
        last_was_sample = 1'b1;
      end
    end

    // Random phases. Phase 0 runs with no idling at all, phase 1 holds the
    // result side off while words keep coming, phase 2 has the widest deadband
    // so nothing gets through, phase 3 puts every range register at a rail.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_block();
      calm = (p == 0);
      lo = SAMPLE_BITS'($urandom_range(0, 1023));
      hi = ($urandom_range(0, 9) == 0) ? lo : SAMPLE_BITS'($urandom_range(0, 1023));
      ol = pick_q16();
      oh = pick_q16();
      off = ($urandom_range(0, 1) == 1) ? '0 : pick_q16();
      th = ($urandom_range(0, 1) == 1) ? SAMPLE_BITS'($urandom_range(0, 3))
                                       : SAMPLE_BITS'($urandom_range(0, 40));
      case ($urandom_range(0, 3))
        0:       wt = WEIGHT_ONE;
        1:       wt = WEIGHT_BITS'($urandom_range(65537, 131071));
        default: wt = WEIGHT_BITS'($urandom_range(1, 65536));
      endcase
      on = 1'($urandom_range(0, 1));
      case (p)
        0, 1: begin
          th = '0;
          on = 1'b0;
        end
        2: begin
          th = 10'd1023;
          wt = '0;
        end
        3: begin
          lo = 10'd1023;
          hi = 10'd0;
          ol = 32'h7FFF_FFFF;
          oh = 32'h8000_0000;
          off = 32'h7FFF_FFFF;
          th = '0;
        end
        default: ;
      endcase
      cfg_write(IDX_INPUT_LOW, with_noise_bits(DATA_BITS'(lo), SAMPLE_BITS));
      cfg_write(IDX_INPUT_HIGH, with_noise_bits(DATA_BITS'(hi), SAMPLE_BITS));
      cfg_write(IDX_OUTPUT_LOW, ol);
      cfg_write(IDX_OUTPUT_HIGH, oh);
      cfg_write(IDX_CHANGE_THRESHOLD, with_noise_bits(DATA_BITS'(th), SAMPLE_BITS));
      cfg_write(IDX_OUTPUT_OFFSET, off);
      cfg_write(IDX_SMOOTHING_WEIGHT, with_noise_bits(DATA_BITS'(wt), WEIGHT_BITS));
      cfg_write(IDX_SMOOTHING_ON, with_noise_bits(DATA_BITS'(on), 1));
      cfg_close();
      if (p == 1) hold_req = 1'b1;
      items = (p == 2) ? QUIET_ITEMS : PHASE_ITEMS;
      for (int k = 0; k < items; k++) begin
        // During the hold-off every word must leave the band, so the
        // inverted held value is offered until the block has backed up.
        if (p == 1 && k < 40) feed_sample(~shadow_held);
        else feed_sample(pick_sample());
      end
    end
    calm = 1'b0;

    settle_block();
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sdrm_pkg.sv
src/sdrm_ifs.sv
src/sdrm_div.sv
src/sdrm_ctrl.sv
src/sdrm_dp.sv
src/smoothed_deadband_range_mapper_unit.sv
test/smoothed_deadband_range_mapper_unit_tb.sv
